// ===== hw/rtl/pof_pkg.sv =====
package pof_pkg;

   localparam int PATTERN_MAX   = 16;
   localparam int POSITION_BITS = 16;
   localparam int LEN_BITS      = $clog2(PATTERN_MAX + 1);
   localparam int IDX_BITS      = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int FIELD_BITS    = 16;
   localparam int FIFO_DEPTH    = 4;
   localparam int CSR_DATA_BITS = 64;
   localparam int CSR_ADDR_BITS = 5;

   typedef enum logic [1:0] {
      REG_PATTERN_LENGTH = 2'd0,
      REG_PATTERN_LOW    = 2'd1,
      REG_PATTERN_HIGH   = 2'd2
   } reg_index_type;

   localparam logic KIND_MATCH   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic [7:0] pattern_byte;
      logic       in_use;
      logic       counted;
   } cell_cfg_type;

   typedef struct packed {
      logic match;
      logic new_char;
   } cell_status_type;

   typedef struct packed {
      logic                  kind;
      logic [FIELD_BITS-1:0] start_position;
      logic [FIELD_BITS-1:0] end_position;
      logic [FIELD_BITS-1:0] occurrence_count;
      logic                  final_result;
   } rsp_item_type;

   function automatic logic is_continuation(input logic [7:0] b);
      return b[7:6] == 2'b10;
   endfunction

endpackage

// ===== hw/rtl/pof_cell.sv =====
module pof_cell
   import pof_pkg::*;
(
   input  logic            clock,
   input  logic            shift_en,
   input  logic [7:0]      byte_in,
   input  cell_cfg_type    cfg,
   output logic [7:0]      byte_out,
   output cell_status_type status
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in_next;

   // status looks at the byte about to be latched, i.e. the window after the shift
   assign byte_in_next    = byte_in;
   assign status.match    = !cfg.in_use || (byte_in_next == cfg.pattern_byte);
   assign status.new_char = cfg.counted && !is_continuation(byte_in_next);
   assign byte_out        = byte_ff;

   always_ff @(posedge clock) begin
      if (shift_en) begin
         byte_ff <= byte_in_next;
      end
   end

endmodule

// ===== hw/rtl/pof_result_fifo.sv =====
module pof_result_fifo
   import pof_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic [1:0]   push_count,
   input  rsp_item_type push_a,
   input  rsp_item_type push_b,
   output logic         room_for_two,
   output logic         out_valid,
   input  logic         out_ready,
   output rsp_item_type out_item
);

   localparam int PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int CNT_BITS = $clog2(FIFO_DEPTH + 1);

   rsp_item_type        mem [FIFO_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [PTR_BITS-1:0] wr_ptr_plus1;
   logic                pop;

   assign out_valid    = count_ff != '0;
   assign out_item     = mem[rd_ptr_ff];
   assign room_for_two = count_ff <= CNT_BITS'(FIFO_DEPTH - 2);
   assign pop          = out_valid && out_ready;
   assign wr_ptr_plus1 = wr_ptr_ff + PTR_BITS'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_BITS'(push_count);
      rd_ptr_in = pop ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_BITS'(push_count) - CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem[wr_ptr_ff] <= push_a;
      end
      if (push_count == 2'd2) begin
         mem[wr_ptr_plus1] <= push_b;
      end
   end

endmodule

// ===== hw/rtl/pattern_occurrence_finder.sv =====
// A match or summary result is written into the output FIFO as its text byte is accepted.
// Throughput: one text byte per cycle while req_tready is high; the 16-cell shift window compares in parallel,
// and a byte that yields both a match and a summary queues two results in the output FIFO.
// req_tready drops only while the 4-entry output FIFO lacks room for two results.
// Synchronous reset clears counters, FIFO and registers (pattern_length = 1, pattern = 0).
module pattern_occurrence_finder
   import pof_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,   // text_byte[7:0]
   input  logic                     req_tlast,   // end_of_text
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [47:0]              rsp_tdata,   // start_position, end_position, occurrence_count
   output logic                     rsp_tuser,   // result_kind
   output logic                     rsp_tlast,   // final_result
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam logic [POSITION_BITS-1:0] POS_MAX   = '1;
   localparam logic [FIELD_BITS-1:0]    COUNT_MAX = '1;

   // configuration registers
   logic [LEN_BITS-1:0]      pattern_length_ff;
   logic [63:0]              pattern_low_ff;
   logic [63:0]              pattern_high_ff;
   logic [1:0]               csr_index;
   logic                     csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:3];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= LEN_BITS'(1);
         pattern_low_ff    <= '0;
         pattern_high_ff   <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_PATTERN_LENGTH: pattern_length_ff <= csr_pwdata[LEN_BITS-1:0];
            REG_PATTERN_LOW:    pattern_low_ff    <= csr_pwdata;
            REG_PATTERN_HIGH:   pattern_high_ff   <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_PATTERN_LENGTH: csr_prdata = CSR_DATA_BITS'(pattern_length_ff);
         REG_PATTERN_LOW:    csr_prdata = pattern_low_ff;
         REG_PATTERN_HIGH:   csr_prdata = pattern_high_ff;
         default:            csr_prdata = '0;
      endcase
   end

   // effective length, clamped to 1..PATTERN_MAX
   logic [LEN_BITS-1:0] len_eff;
   logic [127:0]        pattern_all;

   assign pattern_all = {pattern_high_ff, pattern_low_ff};

   always_comb begin
      if (pattern_length_ff == '0) begin
         len_eff = LEN_BITS'(1);
      end else if (pattern_length_ff > LEN_BITS'(PATTERN_MAX)) begin
         len_eff = LEN_BITS'(PATTERN_MAX);
      end else begin
         len_eff = pattern_length_ff;
      end
   end

   // cell k holds the byte k places back; it lines up with pattern byte len-1-k
   cell_cfg_type        cell_cfg    [PATTERN_MAX];
   cell_status_type     cell_status [PATTERN_MAX];
   logic [7:0]          cell_byte   [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] match_vec;
   logic [PATTERN_MAX-1:0] char_vec;
   logic                accept;

   assign accept = req_tvalid && req_tready;

   always_comb begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
         logic [LEN_BITS-1:0] pidx;
         pidx = len_eff - LEN_BITS'(k) - LEN_BITS'(1);
         cell_cfg[k].pattern_byte = pattern_all[8*pidx[IDX_BITS-1:0] +: 8];
         cell_cfg[k].in_use       = LEN_BITS'(k) < len_eff;
         cell_cfg[k].counted      = LEN_BITS'(k + 1) < len_eff;
         match_vec[k]             = cell_status[k].match;
         char_vec[k]              = cell_status[k].new_char;
      end
   end

   for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
      logic [7:0] byte_feed;
      if (k == 0) begin : g_head
         assign byte_feed = req_tdata;
      end else begin : g_link
         assign byte_feed = cell_byte[k-1];
      end
      pof_cell u_cell (
         .clock    (clock),
         .shift_en (accept),
         .byte_in  (byte_feed),
         .cfg      (cell_cfg[k]),
         .byte_out (cell_byte[k]),
         .status   (cell_status[k])
      );
   end

   // counters
   logic [LEN_BITS-1:0]      fill_ff, fill_in, fill_next;
   logic [POSITION_BITS-1:0] pos_ff, pos_in, pos_next;
   logic [FIELD_BITS-1:0]    total_ff, total_in, total_inc;
   logic [POSITION_BITS-1:0] later_chars;
   logic [POSITION_BITS-1:0] start_pos;
   logic                     hit;
   logic [1:0]               push_count;
   rsp_item_type             match_item, summary_item, push_a, push_b;
   logic                     room_for_two;
   rsp_item_type             out_item;

   always_comb begin
      fill_next   = (fill_ff < LEN_BITS'(PATTERN_MAX)) ? fill_ff + LEN_BITS'(1) : fill_ff;
      pos_next    = (!is_continuation(req_tdata) && pos_ff < POS_MAX)
                    ? pos_ff + POSITION_BITS'(1) : pos_ff;
      total_inc   = (total_ff < COUNT_MAX) ? total_ff + FIELD_BITS'(1) : total_ff;
      later_chars = POSITION_BITS'($countones(char_vec));
      start_pos   = (pos_next >= later_chars) ? pos_next - later_chars : '0;
      hit         = (fill_next >= len_eff) && (&match_vec);

      match_item.kind             = KIND_MATCH;
      match_item.start_position   = FIELD_BITS'(start_pos);
      match_item.end_position     = FIELD_BITS'(pos_next);
      match_item.occurrence_count = total_inc;
      match_item.final_result     = !req_tlast;

      summary_item.kind             = KIND_SUMMARY;
      summary_item.start_position   = '0;
      summary_item.end_position     = '0;
      summary_item.occurrence_count = hit ? total_inc : total_ff;
      summary_item.final_result     = 1'b1;

      push_a     = hit ? match_item : summary_item;
      push_b     = summary_item;
      push_count = '0;
      if (accept) begin
         push_count = 2'(hit) + 2'(req_tlast);
      end

      fill_in  = fill_ff;
      pos_in   = pos_ff;
      total_in = total_ff;
      if (accept) begin
         priority if (req_tlast) begin
            fill_in  = '0;
            pos_in   = '0;
            total_in = '0;
         end else if (hit) begin
            fill_in  = '0;
            pos_in   = pos_next;
            total_in = total_inc;
         end else begin
            fill_in  = fill_next;
            pos_in   = pos_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         pos_ff   <= '0;
         total_ff <= '0;
      end else begin
         fill_ff  <= fill_in;
         pos_ff   <= pos_in;
         total_ff <= total_in;
      end
   end

   pof_result_fifo u_fifo (
      .clock        (clock),
      .reset        (reset),
      .push_count   (push_count),
      .push_a       (push_a),
      .push_b       (push_b),
      .room_for_two (room_for_two),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_item     (out_item)
   );

   assign req_tready = room_for_two;
   assign rsp_tdata  = {out_item.occurrence_count, out_item.end_position,
                        out_item.start_position};
   assign rsp_tuser  = out_item.kind;
   assign rsp_tlast  = out_item.final_result;

endmodule

// ===== tb/tb_pattern_occurrence_finder.sv =====
module tb_pattern_occurrence_finder
   import pof_pkg::*;
();

   localparam int          QUIET_LIMIT     = 2000;
   localparam int          PHASE_COUNT     = 20;
   localparam int          PHASE_BYTES     = 40;
   localparam int          UNUSED_REG      = 3;
   localparam int unsigned POS_LIMIT       = (1 << POSITION_BITS) - 1;
   localparam int unsigned COUNT_LIMIT     = 16'hFFFF;

   typedef struct {
      logic [7:0] text_byte;
      logic       end_of_text;
   } text_item_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [7:0]               req_tdata = '0;   // text_byte[7:0]
   logic                     req_tlast = 1'b0; // end_of_text
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [47:0]              rsp_tdata;        // start_position, end_position, occurrence_count
   logic                     rsp_tuser;        // result_kind
   logic                     rsp_tlast;        // final_result
   logic                     csr_psel = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   pattern_occurrence_finder dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   text_item_type text_queue[$];
   rsp_item_type  expected_results[$];
   int            error_count = 0;
   int            send_idle_pct = 0;
   int            recv_stall_pct = 0;
   int            quiet_cycles = 0;

   // register mirror and matcher state
   logic [4:0]    cfg_length = 5'd1;
   logic [63:0]   cfg_low = '0;
   logic [63:0]   cfg_high = '0;
   logic [7:0]    window [PATTERN_MAX];
   int unsigned   fill_level = 0;
   int unsigned   char_pos = 0;
   int unsigned   match_count = 0;

   // pattern bytes used to build text
   logic [7:0]    pat_bytes [PATTERN_MAX];

   initial begin
      for (int i = 0; i < PATTERN_MAX; i++) window[i] = 8'h00;
   end

   function automatic int unsigned effective_length(input logic [4:0] raw);
      if (raw == 0) return 1;
      if (raw > PATTERN_MAX) return PATTERN_MAX;
      return raw;
   endfunction

   task automatic match_text_byte(input logic [7:0] b, input logic last);
      int unsigned  len;
      int unsigned  later;
      int unsigned  start;
      logic         hit;
      logic [7:0]   w;
      logic [127:0] pattern;
      rsp_item_type r;
      len = effective_length(cfg_length);
      pattern = {cfg_high, cfg_low};
      for (int i = PATTERN_MAX - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = b;
      if (fill_level < PATTERN_MAX) fill_level++;
      if (b[7:6] != 2'b10 && char_pos < POS_LIMIT) char_pos++;
      if (fill_level >= len) begin
         hit = 1'b1;
         later = 0;
         for (int i = 0; i < len; i++) begin
            w = window[len-1-i];
            if (w != pattern[i*8 +: 8]) hit = 1'b0;
            if (i > 0 && w[7:6] != 2'b10) later++;
         end
         if (hit) begin
            start = (char_pos >= later) ? char_pos - later : 0;
            if (match_count < COUNT_LIMIT) match_count++;
            fill_level = 0;
            r.kind = KIND_MATCH;
            r.start_position = start[15:0];
            r.end_position = char_pos[15:0];
            r.occurrence_count = match_count[15:0];
            r.final_result = !last;
            expected_results.push_back(r);
         end
      end
      if (last) begin
         r.kind = KIND_SUMMARY;
         r.start_position = '0;
         r.end_position = '0;
         r.occurrence_count = match_count[15:0];
         r.final_result = 1'b1;
         expected_results.push_back(r);
         fill_level = 0;
         char_pos = 0;
         match_count = 0;
      end
   endtask

   always @(posedge clock) begin : drive_text
      logic offering;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         offering = req_tvalid;
         if (req_tvalid && req_tready) begin
            match_text_byte(text_queue[0].text_byte, text_queue[0].end_of_text);
            void'(text_queue.pop_front());
            offering = 1'b0;
         end
         // a byte on offer stays until taken
         if (!offering) begin
            if (text_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata <= text_queue[0].text_byte;
               req_tlast <= text_queue[0].end_of_text;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_results
      rsp_item_type want;
      rsp_item_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.kind = rsp_tuser;
            got.start_position = rsp_tdata[15:0];
            got.end_position = rsp_tdata[31:16];
            got.occurrence_count = rsp_tdata[47:32];
            got.final_result = rsp_tlast;
            if (expected_results.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result kind %0d start %0d end %0d count %0d last %0d",
                        $time, got.kind, got.start_position, got.end_position,
                        got.occurrence_count, got.final_result);
            end else begin
               want = expected_results.pop_front();
               if (got.kind !== want.kind || got.start_position !== want.start_position ||
                   got.end_position !== want.end_position ||
                   got.occurrence_count !== want.occurrence_count ||
                   got.final_result !== want.final_result) begin
                  error_count++;
                  $display("%0t: mismatch: expected %0d/%0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d/%0d",
                           $time, want.kind, want.start_position, want.end_position,
                           want.occurrence_count, want.final_result,
                           got.kind, got.start_position, got.end_position,
                           got.occurrence_count, got.final_result);
               end
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_register(input int unsigned index, input logic [63:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_BITS'(index * 8);
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (index == int'(REG_PATTERN_LENGTH)) cfg_length = value[4:0];
      else if (index == int'(REG_PATTERN_LOW)) cfg_low = value;
      else if (index == int'(REG_PATTERN_HIGH)) cfg_high = value;
   endtask

   task automatic read_register(input int unsigned index, input logic [63:0] want);
      logic [63:0] got;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= CSR_ADDR_BITS'(index * 8);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      got = csr_prdata;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== want) begin
         error_count++;
         $display("%0t: register %0d readback: expected %h, got %h", $time, index, want, got);
      end
   endtask

   task automatic set_pattern(input logic [4:0] length, input logic [63:0] length_extra);
      logic [127:0] packed_pattern;
      for (int i = 0; i < PATTERN_MAX; i++) packed_pattern[i*8 +: 8] = pat_bytes[i];
      // upper bits of the length word are not stored
      write_register(REG_PATTERN_LENGTH, (length_extra & ~64'h1F) | 64'(length));
      write_register(REG_PATTERN_LOW, packed_pattern[63:0]);
      write_register(REG_PATTERN_HIGH, packed_pattern[127:64]);
      read_register(REG_PATTERN_LENGTH, 64'(cfg_length));
      read_register(REG_PATTERN_LOW, cfg_low);
      read_register(REG_PATTERN_HIGH, cfg_high);
   endtask

   function automatic void append_char(ref logic [7:0] q[$]);
      int unsigned n;
      n = $urandom_range(1, 4);
      case (n)
         1: q.push_back(8'($urandom_range(0, 127)));
         2: q.push_back(8'hC0 | 8'($urandom_range(0, 31)));
         3: q.push_back(8'hE0 | 8'($urandom_range(0, 15)));
         default: q.push_back(8'hF0 | 8'($urandom_range(0, 7)));
      endcase
      for (int i = 1; i < n; i++) q.push_back(8'h80 | 8'($urandom_range(0, 63)));
   endfunction

   // one text, end_of_text on its last byte
   task automatic queue_text(input logic [7:0] bytes[$]);
      text_item_type item;
      foreach (bytes[i]) begin
         item.text_byte = bytes[i];
         item.end_of_text = (i == bytes.size() - 1);
         text_queue.push_back(item);
      end
   endtask

   task automatic make_text(input int unsigned target, input int unsigned len);
      logic [7:0]  text[$];
      int unsigned k;
      int unsigned n;
      while (text.size() < target) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               for (int i = 0; i < len; i++) text.push_back(pat_bytes[i]);
            end
            4: begin
               // broken copy: one byte differs
               k = $urandom_range(0, len - 1);
               for (int i = 0; i < len; i++)
                  text.push_back(i == k ? pat_bytes[i] ^ 8'($urandom_range(1, 255))
                                        : pat_bytes[i]);
            end
            5: begin
               n = $urandom_range(1, len);
               for (int i = 0; i < n; i++) text.push_back(pat_bytes[i]);
            end
            6, 7: text.push_back(pat_bytes[$urandom_range(0, len - 1)]);
            8: append_char(text);
            default: text.push_back(8'($urandom_range(0, 255)));
         endcase
      end
      queue_text(text);
   endtask

   task automatic choose_pattern(input int phase);
      logic [7:0] chars[$];
      logic [7:0] fill;
      case ($urandom_range(0, 3))
         0: for (int i = 0; i < PATTERN_MAX; i++) pat_bytes[i] = 8'h61 + 8'($urandom_range(0, 2));
         1: begin
            while (chars.size() < PATTERN_MAX) append_char(chars);
            for (int i = 0; i < PATTERN_MAX; i++) pat_bytes[i] = chars[i];
         end
         2: for (int i = 0; i < PATTERN_MAX; i++) pat_bytes[i] = 8'($urandom_range(0, 255));
         default: begin
            fill = 8'($urandom_range(0, 255));
            for (int i = 0; i < PATTERN_MAX; i++) pat_bytes[i] = fill;
         end
      endcase
      if (phase == 5) for (int i = 0; i < PATTERN_MAX; i++) pat_bytes[i] = 8'hFF;
      if (phase == 6) for (int i = 0; i < PATTERN_MAX; i++) pat_bytes[i] = 8'h00;
   endtask

   task automatic wait_drained();
      do @(negedge clock); while (text_queue.size() != 0 || expected_results.size() != 0);
      // a byte with no result may still be in the pipe
      repeat (4) @(negedge clock);
   endtask

   initial begin
      logic [7:0]  text[$];
      logic [4:0]  length;
      int          phase_bytes;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // overlapping candidates, continuation bytes at text start, match on the last byte
      pat_bytes = '{8'h61, 8'h62, 8'h61, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
      set_pattern(5'd3, 64'hFFFF_FFFF_FFFF_FFE0);
      send_idle_pct = 23;
      recv_stall_pct = 79;
      @(negedge clock);
      text = '{8'h80, 8'h61, 8'h62, 8'h61, 8'h62, 8'h61, 8'h62, 8'h61, 8'h00, 8'hFF,
               8'hC3, 8'hA9, 8'h61, 8'h62, 8'h61};
      queue_text(text);
      text = '{8'h61};
      queue_text(text);
      wait_drained();

      // two-byte character as pattern; index past the register list is ignored
      pat_bytes = '{8'hC3, 8'hA9, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      set_pattern(5'd2, 64'h0);
      write_register(UNUSED_REG, 64'hFFFF_FFFF_FFFF_FFFF);
      read_register(REG_PATTERN_LENGTH, 64'(cfg_length));
      @(negedge clock);
      text = '{8'hA9, 8'hC3, 8'hA9, 8'hC3, 8'hA9};
      queue_text(text);
      wait_drained();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         if (phase < PHASE_COUNT / 3) begin
            send_idle_pct = 23;
            recv_stall_pct = 79;
         end else if (phase < 2 * PHASE_COUNT / 3) begin
            send_idle_pct = 79;
            recv_stall_pct = 23;
         end else begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         case (phase)
            0: length = 5'd16;
            1: length = 5'd0;
            2: length = 5'd17;
            3: length = 5'd31;
            4: length = 5'd1;
            default: length = ($urandom_range(0, 2) == 0) ? 5'($urandom_range(1, 16))
                                                          : 5'($urandom_range(1, 5));
         endcase
         choose_pattern(phase);
         set_pattern(length, {$urandom, $urandom});
         @(negedge clock);
         phase_bytes = 0;
         while (phase_bytes < PHASE_BYTES) begin
            make_text($urandom_range(1, 40), effective_length(cfg_length));
            phase_bytes = text_queue.size();
         end
         wait_drained();
      end

      repeat (10) @(negedge clock);
      if (expected_results.size() != 0) error_count++;
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/pof_pkg.sv
hw/rtl/pof_cell.sv
hw/rtl/pof_result_fifo.sv
hw/rtl/pattern_occurrence_finder.sv
tb/tb_pattern_occurrence_finder.sv
